@@ hdl/ttr_pkg.sv @@
// ttr_pkg: shared types and constants for the top-ten ranker.
// No dependencies; used by ttr_front, ttr_fifo, ttr_back and top_ten_ranker.
package ttr_pkg;

  localparam int HITS_W = 16;
  localparam int TIME_W = 17;
  localparam int ID_W   = 6;
  localparam int RANK_W = 4;

  // 100.0 in Q7.10
  localparam logic [TIME_W-1:0] NO_HIT_TIME = 17'd102400;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // classified candidate handed from the divider to the list
  typedef struct packed {
    logic              last;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tph;
    logic [HITS_W-1:0] hits;
  } item_t;

  // one slot of the ranked list
  typedef struct packed {
    logic [HITS_W-1:0] hits;
    logic [TIME_W-1:0] tph;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

@@ hdl/ttr_front.sv @@
// ttr_front: input stage, computes time per hit with a bit-serial divider.
// Depends on ttr_pkg; feeds ttr_fifo.
module ttr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ttr_pkg::HITS_W-1:0] in_hits,
  input  logic [ttr_pkg::TIME_W-1:0] in_endt,
  input  logic [ttr_pkg::ID_W-1:0]   in_id,
  input  logic                       in_last,
  input  logic                       fifo_full,
  output logic                       push,
  output ttr_pkg::item_t             push_item
);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_DIV  = 2'd1;
  localparam logic [1:0] FS_PUSH = 2'd2;

  localparam int CNT_W = $clog2(ttr_pkg::TIME_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ttr_pkg::TIME_W - 1);

  logic [1:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [ttr_pkg::TIME_W-1:0]  quo_r, quo_nxt;   // dividend shifts out, quotient shifts in
  logic [ttr_pkg::HITS_W-1:0]  rem_r, rem_nxt;
  logic [ttr_pkg::HITS_W-1:0]  hits_r, hits_nxt;
  logic [ttr_pkg::ID_W-1:0]    id_r, id_nxt;
  logic                        last_r, last_nxt;
  logic [ttr_pkg::HITS_W:0]    rem_sh, rem_sub;
  logic                        ge;

  assign in_ready = (state_r == FS_IDLE);
  assign push     = (state_r == FS_PUSH) && !fifo_full;
  assign push_item = '{last: last_r, id: id_r, tph: quo_r, hits: hits_r};

  assign rem_sh  = {rem_r, quo_r[ttr_pkg::TIME_W-1]};
  assign ge      = (rem_sh >= {1'b0, hits_r});
  assign rem_sub = rem_sh - {1'b0, hits_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    hits_nxt  = hits_r;
    id_nxt    = id_r;
    last_nxt  = last_r;
    case (state_r)
      FS_IDLE: begin
        if (in_valid) begin
          hits_nxt = in_hits;
          id_nxt   = in_id;
          last_nxt = in_last;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          if (in_hits == '0) begin
            quo_nxt   = ttr_pkg::NO_HIT_TIME;
            state_nxt = FS_PUSH;
          end else begin
            quo_nxt   = in_endt;
            state_nxt = FS_DIV;
          end
        end
      end
      FS_DIV: begin
        quo_nxt = {quo_r[ttr_pkg::TIME_W-2:0], ge};
        // remainder stays below the divisor, so 16 bits hold it
        rem_nxt = ge ? rem_sub[ttr_pkg::HITS_W-1:0] : rem_sh[ttr_pkg::HITS_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!fifo_full) begin
          state_nxt = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    hits_r <= hits_nxt;
    id_r   <= id_nxt;
    last_r <= last_nxt;
  end

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FS_DIV) && (cnt_r == LAST_STEP) |=> (state_r == FS_PUSH))
    else $error("divider did not finish after the last step");

endmodule

@@ hdl/ttr_fifo.sv @@
// ttr_fifo: short register queue between the divider and the list.
// Depends on ttr_pkg (item_t, FIFO_DEPTH).
module ttr_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttr_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output ttr_pkg::item_t pop_item
);

  ttr_pkg::item_t               mem_r [ttr_pkg::FIFO_DEPTH];
  logic [ttr_pkg::FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [ttr_pkg::FIFO_CW-1:0]  count_r, count_nxt;

  assign full      = (count_r == ttr_pkg::FIFO_CW'(ttr_pkg::FIFO_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !pop_valid))
    else $error("pop from an empty queue");

endmodule

@@ hdl/ttr_back.sv @@
// ttr_back: ranked list with parallel-compare insertion and shift-out emission.
// Depends on ttr_pkg; pops items from ttr_fifo.
module ttr_back #(
  parameter int LIST_DEPTH = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_valid,
  input  ttr_pkg::item_t             pop_item,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ttr_pkg::RANK_W-1:0] out_rank,
  output logic [ttr_pkg::HITS_W-1:0] out_hits,
  output logic [ttr_pkg::ID_W-1:0]   out_id,
  output logic [ttr_pkg::TIME_W-1:0] out_time,
  output logic                       out_last
);

  localparam int CW = $clog2(LIST_DEPTH);
  localparam logic [CW-1:0] LAST_RANK = CW'(LIST_DEPTH - 1);

  ttr_pkg::entry_t           list_r [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]     q;
  logic                      emit_r;
  logic [CW-1:0]             cnt_r;
  logic                      load;
  logic                      out_valid_r;
  logic [ttr_pkg::RANK_W-1:0] out_rank_r;
  ttr_pkg::entry_t           out_ent_r;
  logic                      out_last_r;
  ttr_pkg::entry_t           new_ent;

  assign pop  = pop_valid && !emit_r;
  assign load = emit_r && (!out_valid_r || out_ready);

  assign new_ent = '{hits: pop_item.hits, tph: pop_item.tph, id: pop_item.id};

  // slot qualifies when its entry ranks below the candidate; the list is
  // kept sorted, so q is a run of zeros followed by ones
  always_comb begin
    for (int j = 0; j < LIST_DEPTH; j++) begin
      q[j] = (list_r[j].hits < pop_item.hits) ||
             ((list_r[j].hits == pop_item.hits) && (list_r[j].tph < pop_item.tph));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LIST_DEPTH; j++) begin
        list_r[j] <= '0;
      end
    end else if (pop) begin
      list_r[0] <= q[0] ? new_ent : list_r[0];
      for (int j = 1; j < LIST_DEPTH; j++) begin
        if (q[j-1]) begin
          list_r[j] <= list_r[j-1];
        end else if (q[j]) begin
          list_r[j] <= new_ent;
        end
      end
    end else if (load) begin
      // shift out from the top; zeros fill in, so the list ends cleared
      for (int j = 0; j < LIST_DEPTH - 1; j++) begin
        list_r[j] <= list_r[j+1];
      end
      list_r[LIST_DEPTH-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && pop_item.last) begin
        emit_r <= 1'b1;
        cnt_r  <= '0;
      end else if (load) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_RANK) begin
          emit_r <= 1'b0;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ent_r  <= list_r[0];
      out_rank_r <= ttr_pkg::RANK_W'(cnt_r);
      out_last_r <= (cnt_r == LAST_RANK);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rank  = out_rank_r;
  assign out_hits  = out_ent_r.hits;
  assign out_id    = out_ent_r.id;
  assign out_time  = out_ent_r.tph;
  assign out_last  = out_last_r;

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    load && (cnt_r == LAST_RANK) |=> !emit_r)
    else $error("emission ran past the last rank");

  for (genvar g = 0; g < LIST_DEPTH - 1; g++) begin : g_sorted
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (list_r[g].hits > list_r[g+1].hits) ||
      ((list_r[g].hits == list_r[g+1].hits) && (list_r[g].tph >= list_r[g+1].tph)))
      else $error("ranked list out of order");
  end

endmodule

@@ hdl/top_ten_ranker.sv @@
// top_ten_ranker: ranks candidates by hit count, then time per hit.
// A candidate passes the 17-step bit-serial divider, then the queue, then list insertion;
// a zero hit count skips the divider. A new candidate is taken only after the previous one
// has been pushed into the queue; the push waits while the queue is full. A last candidate
// makes the list stage emit LIST_DEPTH entries, overlapped with the divider through the queue.
// Synchronous active-low reset clears the list and all control state at once.
module top_ten_ranker #(
  parameter int LIST_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // hit_count[15:0], end_time[32:16], candidate_id[38:33]
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // rank[3:0], ranked_hits[19:4], ranked_id[25:20],
                                  // ranked_time[42:26]
  output logic        out_tlast   // last_of_list
);

  logic                       fifo_full, push, pop, pop_valid;
  ttr_pkg::item_t             push_item, pop_item;
  logic [ttr_pkg::RANK_W-1:0] o_rank;
  logic [ttr_pkg::HITS_W-1:0] o_hits;
  logic [ttr_pkg::ID_W-1:0]   o_id;
  logic [ttr_pkg::TIME_W-1:0] o_time;

  ttr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_hits   (in_tdata[15:0]),
    .in_endt   (in_tdata[32:16]),
    .in_id     (in_tdata[38:33]),
    .in_last   (in_tlast),
    .fifo_full (fifo_full),
    .push      (push),
    .push_item (push_item)
  );

  ttr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  ttr_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rank  (o_rank),
    .out_hits  (o_hits),
    .out_id    (o_id),
    .out_time  (o_time),
    .out_last  (out_tlast)
  );

  assign out_tdata = {5'b0, o_time, o_id, o_hits, o_rank};

endmodule
